[hdl/cst_pkg.sv]
package cst_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CntW   = 16;
  localparam int unsigned OpenW  = 8;
  localparam int unsigned UtilW  = 17;
  localparam int unsigned NodeW  = 8;
  localparam int unsigned QuotW  = 32;

  localparam logic [OpenW-1:0] OpenMax = '1;
  localparam logic [CntW-1:0]  GapsMax = '1;

  typedef enum logic [1:0] {
    CMD_UP    = 2'd0,
    CMD_DOWN  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // one row of per-node statistics
  typedef struct packed {
    logic [OpenW-1:0] open_cnt;
    logic [CntW-1:0]  enc;
    logic [TimeW-1:0] sep_start;
    logic             sep_seen;
    logic [SumW-1:0]  gap_sum;
    logic [TimeW-1:0] gap_avg;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_DIV_AVG,
    ST_DIV_UTIL,
    ST_OUT
  } state_t;

endpackage

[hdl/cst_div.sv]
module cst_div
  import cst_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SumW-1:0] dividend,
  input  logic [32:0]     divisor,
  output logic            done,
  output logic [SumW-1:0] quotient
);

  // restoring division, one quotient bit a cycle
  logic [SumW-1:0] quo_r, quo_nxt;
  logic [33:0]     rem_r, rem_nxt;
  logic [32:0]     dvs_r, dvs_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [33:0]     trial;
  logic [33:0]     shifted;

  always_comb begin
    shifted  = {rem_r[32:0], quo_r[SumW-1]};
    trial    = shifted - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'(SumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[SumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/contact_separation_tracker_core.sv]
// channel | direction | handshake        | fields
// in_     | input     | in_valid/in_stall | command, node, current_time
// out_    | output    | out_valid/out_stall | utility, average_gap, average_valid,
//         |           |                  | time_apart, apart_valid
// one item at a time; an up that closes a gap runs two 48-step bit-serial divisions
// (average, then utility) before the next accept, any other item with an average
// only the utility division, none when no average yet
// after reset a clearing pass writes every row, input stalled
// out_stall holds the result register; the next item waits until it is taken
module contact_separation_tracker_core
  import cst_pkg::*;
#(
  parameter int unsigned NODES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [NodeW-1:0]    in_node,
  input  logic [TimeW-1:0]    in_current_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [UtilW-1:0]    out_utility,
  output logic [TimeW-1:0]    out_average_gap,
  output logic                out_average_valid,
  output logic [TimeW-1:0]    out_time_apart,
  output logic                out_apart_valid
);

  localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned NODE_ABOVE = AW + 1;
  localparam int unsigned IW = (NODE_ABOVE > NodeW) ? NODE_ABOVE : NodeW;

  // statistics memory, one row per node
  row_t mem [NODES];
  row_t rd_r;
  row_t row_r, row_nxt;

  state_t state_r, state_nxt;

  // clearing pass counter
  logic [AW:0]  clr_r, clr_nxt;
  logic         clr_busy;

  // latched item
  logic [1:0]       cmd_r;
  logic [AW-1:0]    addr_r;
  logic             oor_r;
  logic [TimeW-1:0] now_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  row_t             wr_data;
  logic [AW-1:0]    rd_addr;

  // divider
  logic             div_start;
  logic [SumW-1:0]  div_dividend;
  logic [32:0]      div_divisor;
  logic             div_done;
  logic [SumW-1:0]  div_quo;

  // result register
  logic             ov_r, ov_nxt;
  logic [UtilW-1:0] util_r, util_nxt;
  logic [TimeW-1:0] avg_r, avg_nxt;
  logic             avgv_r, avgv_nxt;
  logic [TimeW-1:0] apart_r, apart_nxt;
  logic             apartv_r, apartv_nxt;

  logic [TimeW-1:0] elapsed;
  logic             accept;
  logic [IW-1:0]    node_wide;

  assign clr_busy  = (clr_r < (AW+1)'(NODES));
  assign in_stall  = clr_busy || (state_r != ST_IDLE) || ov_r;
  assign accept    = in_valid && !in_stall;
  assign node_wide = IW'(in_node);
  assign elapsed   = (now_r >= row_r.sep_start) ? (now_r - row_r.sep_start) : '0;
  // read the new node's row at the accepting edge
  assign rd_addr   = accept ? node_wide[AW-1:0] : addr_r;

  cst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (accept) state_nxt = ST_READ;
      ST_READ:     state_nxt = oor_r ? ST_OUT : ST_UPD;
      ST_UPD: begin
        if (row_nxt.enc != row_r.enc) state_nxt = ST_DIV_AVG;
        else if (row_nxt.enc != '0)   state_nxt = ST_DIV_UTIL;
        else                          state_nxt = ST_OUT;
      end
      ST_DIV_AVG:  if (div_done) state_nxt = ST_DIV_UTIL;
      ST_DIV_UTIL: if (div_done) state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // row update and datapath control
  always_comb begin
    row_nxt      = row_r;
    wr_en        = 1'b0;
    wr_addr      = addr_r;
    wr_data      = row_r;
    div_start    = 1'b0;
    div_dividend = row_r.gap_sum;
    div_divisor  = {17'd0, row_r.enc};
    ov_nxt       = ov_r;
    util_nxt     = util_r;
    avg_nxt      = avg_r;
    avgv_nxt     = avgv_r;
    apart_nxt    = apart_r;
    apartv_nxt   = apartv_r;
    clr_nxt      = clr_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (clr_busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_r[AW-1:0];
      wr_data = '0;
      clr_nxt = clr_r + 1'b1;
    end
    case (state_r)
      ST_READ: row_nxt = rd_r;
      ST_UPD: begin
        case (cmd_t'(cmd_r))
          CMD_UP: begin
            if (row_r.open_cnt != OpenMax) row_nxt.open_cnt = row_r.open_cnt + 1'b1;
            // first up after a separation closes a gap
            if (row_r.open_cnt == '0 && row_r.sep_seen && row_r.enc != GapsMax) begin
              row_nxt.enc     = row_r.enc + 1'b1;
              row_nxt.gap_sum = row_r.gap_sum + SumW'(elapsed);
            end
          end
          CMD_DOWN: begin
            if (row_r.open_cnt != '0) begin
              row_nxt.open_cnt = row_r.open_cnt - 1'b1;
              if (row_r.open_cnt == OpenW'(1)) begin
                row_nxt.sep_start = now_r;
                row_nxt.sep_seen  = 1'b1;
              end
            end
          end
          default: ;
        endcase
        // time apart uses the updated separation start
        apartv_nxt = row_nxt.sep_seen;
        apart_nxt  = (row_nxt.sep_seen && now_r >= row_nxt.sep_start)
                     ? (now_r - row_nxt.sep_start) : '0;
        if (row_nxt.enc != row_r.enc) begin
          div_start    = 1'b1;
          div_dividend = row_nxt.gap_sum;
          div_divisor  = {17'd0, row_nxt.enc};
        end else if (row_nxt.enc != '0) begin
          div_start    = 1'b1;
          div_dividend = SumW'(65536);
          div_divisor  = {1'b0, row_r.gap_avg} + 33'd1;
        end
        wr_en   = 1'b1;
        wr_data = row_nxt;
      end
      ST_DIV_AVG: if (div_done) begin
        row_nxt.gap_avg = div_quo[TimeW-1:0];
        wr_en        = 1'b1;
        wr_data      = row_nxt;
        div_start    = 1'b1;
        div_dividend = SumW'(65536);
        div_divisor  = {1'b0, div_quo[TimeW-1:0]} + 33'd1;
      end
      ST_DIV_UTIL: if (div_done) util_nxt = div_quo[UtilW-1:0];
      ST_OUT: begin
        ov_nxt   = 1'b1;
        avgv_nxt = !oor_r && row_r.enc != '0;
        avg_nxt  = avgv_nxt ? row_r.gap_avg : '0;
        if (!avgv_nxt) util_nxt = '0;
        if (oor_r) begin
          apart_nxt  = '0;
          apartv_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    util_r  <= util_nxt;
    avg_r   <= avg_nxt;
    avgv_r  <= avgv_nxt;
    apart_r <= apart_nxt;
    apartv_r <= apartv_nxt;
    if (accept) begin
      cmd_r  <= in_command;
      addr_r <= node_wide[AW-1:0];
      oor_r  <= (node_wide >= IW'(NODES));
      now_r  <= in_current_time;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_utility       = util_r;
  assign out_average_gap   = avg_r;
  assign out_average_valid = avgv_r;
  assign out_time_apart    = apart_r;
  assign out_apart_valid   = apartv_r;

endmodule

[sim/tb.sv]
module tb
  import cst_pkg::*;
;

  localparam int unsigned NODES = 256;

  typedef struct packed {
    logic [UtilW-1:0] utility;
    logic [TimeW-1:0] average_gap;
    logic             average_valid;
    logic [TimeW-1:0] time_apart;
    logic             apart_valid;
  } gap_report_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [NodeW-1:0] node;
    logic [TimeW-1:0] now;
    logic             typed;  // expected result written out in the row
    gap_report_t      want;
  } contact_row_t;

  localparam gap_report_t NO_STATS = '{17'd0, 32'd0, 1'b0, 32'd0, 1'b0};
  localparam int unsigned DIRECTED = 22;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_QUERY;
  logic [NodeW-1:0] in_node = '0;
  logic [TimeW-1:0] in_current_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [UtilW-1:0] out_utility;
  logic [TimeW-1:0] out_average_gap;
  logic out_average_valid;
  logic [TimeW-1:0] out_time_apart;
  logic out_apart_valid;

  contact_separation_tracker_core #(.NODES(NODES)) dut (.*);

  always #5 clk = ~clk;

  // shadow copy of the per-node statistics table
  logic [OpenW-1:0] shadow_open [NODES];
  logic [CntW-1:0]  shadow_gaps [NODES];
  logic [TimeW-1:0] shadow_sep_start [NODES];
  logic             shadow_sep_seen [NODES];
  logic [SumW-1:0]  shadow_gap_sum [NODES];
  logic [TimeW-1:0] shadow_gap_avg [NODES];

  gap_report_t pending_reports[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [TimeW-1:0] clock_ticks = '0;

  contact_row_t plan [DIRECTED] = '{
    // query right after reset
    '{CMD_QUERY, 8'd0, 32'd0, 1'b1, NO_STATS},
    // down with nothing open is ignored
    '{CMD_DOWN, 8'd2, 32'd5, 1'b1, NO_STATS},
    // unknown command acts as a query
    '{CMD_NONE, 8'd255, 32'd7, 1'b1, NO_STATS},
    // first up ever measures no gap
    '{CMD_UP, 8'd1, 32'd10, 1'b1, NO_STATS},
    // nested up
    '{CMD_UP, 8'd1, 32'd11, 1'b1, NO_STATS},
    '{CMD_DOWN, 8'd1, 32'd12, 1'b1, NO_STATS},
    // last contact closes, separation starts
    '{CMD_DOWN, 8'd1, 32'd20, 1'b1, '{17'd0, 32'd0, 1'b0, 32'd0, 1'b1}},
    '{CMD_QUERY, 8'd1, 32'd100, 1'b1, '{17'd0, 32'd0, 1'b0, 32'd80, 1'b1}},
    '{CMD_UP, 8'd1, 32'd100, 1'b0, NO_STATS},
    '{CMD_DOWN, 8'd1, 32'd100, 1'b0, NO_STATS},
    '{CMD_UP, 8'd1, 32'd100, 1'b0, NO_STATS},
    // zero average gives full utility
    '{CMD_UP, 8'd3, 32'd200, 1'b0, NO_STATS},
    '{CMD_DOWN, 8'd3, 32'd200, 1'b0, NO_STATS},
    '{CMD_UP, 8'd3, 32'd200, 1'b1, '{17'd65536, 32'd0, 1'b1, 32'd0, 1'b1}},
    '{CMD_DOWN, 8'd3, 32'hFFFF_FFFF, 1'b0, NO_STATS},
    '{CMD_QUERY, 8'd3, 32'hFFFF_FFFF, 1'b0, NO_STATS},
    // time going back: gap taken as zero
    '{CMD_UP, 8'd3, 32'd16, 1'b0, NO_STATS},
    '{CMD_QUERY, 8'd3, 32'd0, 1'b0, NO_STATS},
    // largest possible gap, utility drops to zero
    '{CMD_UP, 8'd4, 32'd0, 1'b0, NO_STATS},
    '{CMD_DOWN, 8'd4, 32'd0, 1'b0, NO_STATS},
    '{CMD_UP, 8'd4, 32'hFFFF_FFFF, 1'b0, NO_STATS},
    '{CMD_QUERY, 8'd4, 32'hFFFF_FFFF, 1'b0, NO_STATS}
  };

  // apply one item to the shadow table and return what the block reports
  function automatic gap_report_t track_contact(cmd_t cmd, logic [NodeW-1:0] n,
                                                logic [TimeW-1:0] now);
    gap_report_t r;
    logic [OpenW-1:0] prior;
    logic [TimeW-1:0] gap;
    r = NO_STATS;
    if (cmd == CMD_UP) begin
      prior = shadow_open[n];
      if (prior != OpenMax) shadow_open[n] = prior + 1'b1;
      if (prior == '0 && shadow_sep_seen[n] && shadow_gaps[n] != GapsMax) begin
        gap = (now >= shadow_sep_start[n]) ? now - shadow_sep_start[n] : '0;
        shadow_gaps[n] = shadow_gaps[n] + 1'b1;
        shadow_gap_sum[n] = shadow_gap_sum[n] + {16'd0, gap};
        shadow_gap_avg[n] = TimeW'(shadow_gap_sum[n] / {32'd0, shadow_gaps[n]});
      end
    end else if (cmd == CMD_DOWN && shadow_open[n] != '0) begin
      shadow_open[n] = shadow_open[n] - 1'b1;
      if (shadow_open[n] == '0) begin
        shadow_sep_start[n] = now;
        shadow_sep_seen[n] = 1'b1;
      end
    end
    if (shadow_gaps[n] != '0) begin
      r.utility = UtilW'(64'd65536 / ({32'd0, shadow_gap_avg[n]} + 64'd1));
      r.average_gap = shadow_gap_avg[n];
      r.average_valid = 1'b1;
    end
    if (shadow_sep_seen[n]) begin
      r.time_apart = (now >= shadow_sep_start[n]) ? now - shadow_sep_start[n] : '0;
      r.apart_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  // drive one item at the falling edge and hold it until accepted
  task automatic send_contact(cmd_t cmd, logic [NodeW-1:0] n, logic [TimeW-1:0] now,
                              logic typed, gap_report_t want);
    gap_report_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_node <= n;
    in_current_time <= now;
    do @(posedge clk); while (in_stall);
    predicted = track_contact(cmd, n, now);
    pending_reports.push_back(typed ? want : predicted);
  endtask

  // random item, biased toward a few busy nodes so gaps and nesting happen
  task automatic send_random;
    int unsigned roll;
    cmd_t cmd;
    logic [NodeW-1:0] n;
    roll = $urandom_range(99);
    cmd = roll < 45 ? CMD_UP : roll < 85 ? CMD_DOWN : roll < 95 ? CMD_QUERY : CMD_NONE;
    n = ($urandom_range(99) < 70) ? NodeW'($urandom_range(7)) : NodeW'($urandom);
    roll = $urandom_range(99);
    if (roll < 2) clock_ticks = $urandom;
    else if (roll < 5) clock_ticks = clock_ticks - TimeW'($urandom_range(500));
    else clock_ticks = clock_ticks + TimeW'($urandom_range(1000));
    send_contact(cmd, n, clock_ticks, 1'b0, NO_STATS);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("result with no item outstanding");
        errors++;
      end else begin
        gap_report_t w;
        w = pending_reports.pop_front();
        if (out_utility !== w.utility) report("utility", out_utility, w.utility);
        if (out_average_gap !== w.average_gap)
          report("average_gap", out_average_gap, w.average_gap);
        if (out_average_valid !== w.average_valid)
          report("average_valid", out_average_valid, w.average_valid);
        if (out_time_apart !== w.time_apart)
          report("time_apart", out_time_apart, w.time_apart);
        if (out_apart_valid !== w.apart_valid)
          report("apart_valid", out_apart_valid, w.apart_valid);
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      shadow_open[i] = '0;
      shadow_gaps[i] = '0;
      shadow_sep_start[i] = '0;
      shadow_sep_seen[i] = 1'b0;
      shadow_gap_sum[i] = '0;
      shadow_gap_avg[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_contact(plan[i].cmd, plan[i].node, plan[i].now,
                                   plan[i].typed, plan[i].want);

    send_idle_pct = 7;
    recv_idle_pct = 73;
    repeat (700) send_random();

    // hold off until everything outstanding has drained
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);

    send_idle_pct = 73;
    recv_idle_pct = 7;
    repeat (700) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // drive one node into open-count saturation and back out
    repeat (260) send_contact(CMD_UP, 8'd200, clock_ticks, 1'b0, NO_STATS);
    repeat (260) send_contact(CMD_DOWN, 8'd200, clock_ticks + 32'd50, 1'b0, NO_STATS);
    send_contact(CMD_UP, 8'd200, clock_ticks + 32'd90, 1'b0, NO_STATS);
    repeat (300) send_random();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hdl/cst_pkg.sv
hdl/cst_div.sv
hdl/contact_separation_tracker_core.sv
sim/tb.sv
